// ===== rtl/rmcc_pkg.sv =====
// Shared types and constants of the RGB matrix color converter.
package rmcc_pkg;

	localparam int COEF_WIDTH  = 16;
	localparam int PIXEL_WIDTH = 8;
	localparam int FRAC_BITS   = 12;
	localparam int OUT_WIDTH   = 26;
	localparam int NUM_ROWS    = 3;
	localparam int ROW_WIDTH   = NUM_ROWS * COEF_WIDTH;
	localparam int PROD_WIDTH  = COEF_WIDTH + PIXEL_WIDTH + 1;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	localparam int CFG_IDX_W   = 3;

	// Coefficient slots inside a row word, packed high to low as R, G, B.
	localparam int SLOT_RED   = 2;
	localparam int SLOT_GREEN = 1;
	localparam int SLOT_BLUE  = 0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0 = 3'd0,
		CFG_ROW1 = 3'd1,
		CFG_ROW2 = 3'd2,
		CFG_MODE = 3'd3
	} cfg_idx_t;

	typedef enum logic {
		MODE_MATRIX = 1'b0,
		MODE_CMY    = 1'b1
	} conv_mode_t;

	localparam logic [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1 << FRAC_BITS);
	localparam logic [COEF_WIDTH-1:0] COEF_ZERO = '0;

	localparam logic [ROW_WIDTH-1:0] ROW0_RESET = {COEF_ONE, COEF_ZERO, COEF_ZERO};
	localparam logic [ROW_WIDTH-1:0] ROW1_RESET = {COEF_ZERO, COEF_ONE, COEF_ZERO};
	localparam logic [ROW_WIDTH-1:0] ROW2_RESET = {COEF_ZERO, COEF_ZERO, COEF_ONE};

	typedef logic [PIXEL_WIDTH-1:0] pixel_t;
	typedef logic signed [OUT_WIDTH-1:0] chan_t;

	typedef struct packed {
		pixel_t red;
		pixel_t green;
		pixel_t blue;
	} pix_t;

	typedef struct packed {
		logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] row;
		conv_mode_t                          mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		row:  {ROW2_RESET, ROW1_RESET, ROW0_RESET},
		mode: MODE_MATRIX
	};

	// Load strobes of the datapath stages behind the input register.
	typedef struct packed {
		logic s2;
		logic s3;
	} pipe_ld_t;

endpackage

// ===== rtl/rmcc_pix_if.sv =====
// Pixel request channel and converted channel result interfaces.
interface rmcc_pix_if;
	import rmcc_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t red;
	pixel_t green;
	pixel_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rmcc_chan_if;
	import rmcc_pkg::*;

	logic  valid;
	logic  ready;
	chan_t chan0;
	chan_t chan1;
	chan_t chan2;

	modport source (output valid, output chan0, output chan1, output chan2, input ready);
	modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

// ===== rtl/rmcc_cfg_regs.sv =====
// Configuration register file: three coefficient rows and the conversion mode.
module rmcc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rmcc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rmcc_pkg::ROW_WIDTH-1:0]   cfg_wdata,
	output rmcc_pkg::cfg_t                   cfg
);
	import rmcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROW0: cfg_q.row[0] <= cfg_wdata;
				CFG_ROW1: cfg_q.row[1] <= cfg_wdata;
				CFG_ROW2: cfg_q.row[2] <= cfg_wdata;
				CFG_MODE: cfg_q.mode <= conv_mode_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rmcc_row_mac.sv =====
// One output channel: three products in the second stage, their sum (or the CMY complement) in the third.
module rmcc_row_mac (
	input  logic                           clk,
	input  rmcc_pkg::pipe_ld_t             ld,
	input  logic [rmcc_pkg::ROW_WIDTH-1:0] coefs,
	input  rmcc_pkg::pix_t                 pix_s1,
	input  rmcc_pkg::pixel_t               comp_s1,
	input  rmcc_pkg::conv_mode_t           mode_s1,
	output rmcc_pkg::chan_t                chan
);
	import rmcc_pkg::*;

	logic signed [COEF_WIDTH-1:0]  coef_r;
	logic signed [COEF_WIDTH-1:0]  coef_g;
	logic signed [COEF_WIDTH-1:0]  coef_b;
	logic signed [PIXEL_WIDTH:0]   px_r;
	logic signed [PIXEL_WIDTH:0]   px_g;
	logic signed [PIXEL_WIDTH:0]   px_b;
	logic signed [PROD_WIDTH-1:0]  prod_r_s2;
	logic signed [PROD_WIDTH-1:0]  prod_g_s2;
	logic signed [PROD_WIDTH-1:0]  prod_b_s2;
	pixel_t                        cmy_s2;
	conv_mode_t                    mode_s2;
	logic signed [SUM_WIDTH-1:0]   sum;
	chan_t                         chan_s3;

	assign coef_r = $signed(coefs[SLOT_RED*COEF_WIDTH +: COEF_WIDTH]);
	assign coef_g = $signed(coefs[SLOT_GREEN*COEF_WIDTH +: COEF_WIDTH]);
	assign coef_b = $signed(coefs[SLOT_BLUE*COEF_WIDTH +: COEF_WIDTH]);
	assign px_r   = $signed({1'b0, pix_s1.red});
	assign px_g   = $signed({1'b0, pix_s1.green});
	assign px_b   = $signed({1'b0, pix_s1.blue});

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			prod_r_s2 <= coef_r * px_r;
			prod_g_s2 <= coef_g * px_g;
			prod_b_s2 <= coef_b * px_b;
			cmy_s2    <= {PIXEL_WIDTH{1'b1}} - comp_s1;
			mode_s2   <= mode_s1;
		end
	end

	assign sum = SUM_WIDTH'(prod_r_s2) + SUM_WIDTH'(prod_g_s2) + SUM_WIDTH'(prod_b_s2);

	// The matrix sum never exceeds the channel range, so truncation is exact.
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			if (mode_s2 == MODE_CMY) begin
				chan_s3 <= OUT_WIDTH'({cmy_s2, {FRAC_BITS{1'b0}}});
			end else begin
				chan_s3 <= OUT_WIDTH'(sum);
			end
		end
	end

	assign chan = chan_s3;

endmodule

// ===== rtl/rgb_matrix_colour_convert.sv =====
// Pipeline: an accepted request passes the input, product and sum registers.
// Throughput: one pixel per cycle; the three-stage register pipeline with
// per-stage valid bits fills any bubble and holds everything on a stall.
// Reset: arst_n clears the stage valid bits and loads identity coefficients
// with the matrix mode; payload registers are not reset.
module rgb_matrix_colour_convert (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmcc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rmcc_pkg::ROW_WIDTH-1:0] cfg_wdata,
	rmcc_pix_if.sink                       pix,
	rmcc_chan_if.source                    res
);
	import rmcc_pkg::*;

	cfg_t       cfg;
	logic       v_s1;
	logic       v_s2;
	logic       v_s3;
	logic       en_s1;
	logic       en_s2;
	logic       en_s3;
	pipe_ld_t   ld;
	pix_t       pix_s1;
	conv_mode_t mode_s1;
	chan_t      chan [NUM_ROWS];

	rmcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// A stage may take new data when it is empty or its content moves on.
	assign en_s3 = !v_s3 || res.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix.ready = en_s1;
	assign ld.s2 = en_s2 && v_s1;
	assign ld.s3 = en_s3 && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pix.valid) begin
			pix_s1.red   <= pix.red;
			pix_s1.green <= pix.green;
			pix_s1.blue  <= pix.blue;
			mode_s1      <= cfg.mode;
		end
	end

	rmcc_row_mac u_row0 (
		.clk     (clk),
		.ld      (ld),
		.coefs   (cfg.row[0]),
		.pix_s1  (pix_s1),
		.comp_s1 (pix_s1.red),
		.mode_s1 (mode_s1),
		.chan    (chan[0])
	);

	rmcc_row_mac u_row1 (
		.clk     (clk),
		.ld      (ld),
		.coefs   (cfg.row[1]),
		.pix_s1  (pix_s1),
		.comp_s1 (pix_s1.green),
		.mode_s1 (mode_s1),
		.chan    (chan[1])
	);

	rmcc_row_mac u_row2 (
		.clk     (clk),
		.ld      (ld),
		.coefs   (cfg.row[2]),
		.pix_s1  (pix_s1),
		.comp_s1 (pix_s1.blue),
		.mode_s1 (mode_s1),
		.chan    (chan[2])
	);

	assign res.valid = v_s3;
	assign res.chan0 = chan[0];
	assign res.chan1 = chan[1];
	assign res.chan2 = chan[2];

`ifndef SYNTHESIS
	// Requests are refused only when every stage holds an item.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (v_s1 && v_s2 && v_s3))
		else $error("pixel request refused with a free stage");

	// An accepted request lands in the first stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> v_s1)
		else $error("accepted pixel lost at first stage");

	// An item leaving the second stage shows up as a result.
	a_s2_moves_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en_s3) |=> v_s3)
		else $error("item lost between second and third stage");
`endif

endmodule
